### hdl/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define XIE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define XIE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/xie_pkg.sv
// Package for the x86-64 instruction encoder: command codes, byte constants
// and the descriptor that carries one encoded instruction. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xie_pkg;

    typedef enum logic [3:0] {
        CMD_ADD_REG_TO_MEM = 4'd0,
        CMD_ADD_MEM_TO_REG = 4'd1,
        CMD_ADD_REG_REG    = 4'd2,
        CMD_ADD_IMM32      = 4'd3,
        CMD_MOV_IMM        = 4'd4,
        CMD_MOV_IMM64      = 4'd5,
        CMD_MOV_REG_REG    = 4'd6,
        CMD_MOV_REG_TO_MEM = 4'd7,
        CMD_MOV_MEM_TO_REG = 4'd8,
        CMD_CALL_REG       = 4'd9,
        CMD_PUSH_RBP       = 4'd10,
        CMD_LEAVE          = 4'd11,
        CMD_RET            = 4'd12
    } t_cmd;

    localparam int unsigned MAX_BYTES = 10;

    localparam logic [7:0] REX_PREFIX = 8'h40;
    localparam logic [7:0] REX_W      = 8'h08;
    localparam logic [7:0] REX_R      = 8'h04;
    localparam logic [7:0] REX_B      = 8'h01;
    localparam logic [7:0] OP_ADD_RM  = 8'h01;
    localparam logic [7:0] OP_ADD_MR  = 8'h03;
    localparam logic [7:0] OP_ADD_RAX = 8'h05;
    localparam logic [7:0] OP_GRP1    = 8'h81;
    localparam logic [7:0] OP_MOV_RM  = 8'h89;
    localparam logic [7:0] OP_MOV_MR  = 8'h8B;
    localparam logic [7:0] OP_MOV_IMM = 8'hB8;
    localparam logic [7:0] OP_GRP5    = 8'hFF;
    localparam logic [7:0] OP_PUSH_BP = 8'h55;
    localparam logic [7:0] OP_LEAVE   = 8'hC9;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] MODRM_REG  = 8'hC0;
    localparam logic [7:0] MODRM_CALL = 8'hD0;
    localparam logic [7:0] SIB_NOIDX  = 8'h24;

    typedef logic [MAX_BYTES-1:0][7:0] t_byte_vec;

    // One encoded instruction: bytes in memory order from index 0.
    typedef struct packed {
        t_byte_vec   bytes;
        logic [3:0]  len;
    } t_desc;

endpackage

`default_nettype wire

### hdl/x64_instruction_encoder_unit.sv
// Top level of the x86-64 instruction encoder.
// Depends on xie_pkg, xie_front, xie_queue and xie_back.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_ready    i_cmd, i_reg_operand, i_base_operand,
//                                             i_displacement, i_immediate
//   code      out        o_valid / i_ready    o_code_byte, o_last
//
// One code byte leaves per cycle while i_ready is high; an instruction is 1 to 10
// bytes long. The front end decodes in the accept cycle and writes the queue; the
// first byte then passes through the queue, the back end byte buffer and the output register.
// Reset (synchronous, active low) empties the queue and the output register.
// A stalled output holds its byte; the front end keeps taking requests until
// the queue is full. Undefined command codes are taken and produce no bytes.
`timescale 1ns / 1ps
`default_nettype none

module x64_instruction_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [3:0]         i_cmd,
    input  wire logic [3:0]         i_reg_operand,
    input  wire logic [3:0]         i_base_operand,
    input  wire logic signed [31:0] i_displacement,
    input  wire logic [63:0]        i_immediate,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_code_byte,
    output logic                    o_last
);
    import xie_pkg::*;

    t_desc front_desc;
    t_desc q_desc;
    logic  q_full;
    logic  q_nonempty;
    logic  q_push;
    logic  q_pop;

    // Decode the request into its byte string.
    xie_front u_front (
        .i_cmd          (i_cmd),
        .i_reg_operand  (i_reg_operand),
        .i_base_operand (i_base_operand),
        .i_displacement (i_displacement),
        .i_immediate    (i_immediate),
        .o_desc         (front_desc)
    );

    // Accept whenever the queue has room; drop requests that encode to nothing.
    assign o_ready = !q_full;
    assign q_push  = i_valid && !q_full && (front_desc.len != 4'd0);

    xie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_desc     (front_desc),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_desc     (q_desc)
    );

    // Stream bytes; the next instruction is loaded as the last byte moves out.
    xie_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_desc     (q_desc),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_byte  (o_code_byte),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### hdl/xie_front.sv
// Front end of the encoder: decodes one request into its byte string.
// Depends on xie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xie_front (
    input  wire logic [3:0]         i_cmd,
    input  wire logic [3:0]         i_reg_operand,
    input  wire logic [3:0]         i_base_operand,
    input  wire logic signed [31:0] i_displacement,
    input  wire logic [63:0]        i_immediate,
    output xie_pkg::t_desc          o_desc
);
    import xie_pkg::*;

    logic [2:0]  lo_reg;
    logic [2:0]  lo_base;
    logic [7:0]  rex_rb;
    logic [7:0]  rex_b;
    logic        disp_zero;
    logic        disp_short;
    logic [1:0]  mode;
    logic        has_sib;
    logic [3:0]  disp_len;
    logic [5:0][7:0] mem_bytes;
    logic [3:0]  mem_len;
    logic        imm_small;
    t_desc       desc;

    assign lo_reg  = i_reg_operand[2:0];
    assign lo_base = i_base_operand[2:0];
    assign rex_rb  = REX_PREFIX | REX_W | (i_reg_operand[3] ? REX_R : 8'h00)
                   | (i_base_operand[3] ? REX_B : 8'h00);
    assign rex_b   = REX_PREFIX | REX_W | (i_base_operand[3] ? REX_B : 8'h00);
    assign imm_small = (i_immediate[63:32] == 32'h0);

    // Memory operand: ModRM, optional SIB, displacement of none, 8 or 32 bits.
    always_comb begin
        disp_zero  = (i_displacement == 32'sd0);
        disp_short = (i_displacement[31:7] == 25'h0) || (i_displacement[31:7] == '1);
        if (disp_zero && (lo_base != 3'd5)) begin
            mode     = 2'd0;
            disp_len = 4'd0;
        end else if (disp_short) begin
            mode     = 2'd1;
            disp_len = 4'd1;
        end else begin
            mode     = 2'd2;
            disp_len = 4'd4;
        end
        has_sib      = (lo_base == 3'd4);
        mem_bytes    = '0;
        mem_bytes[0] = {mode, lo_reg, lo_base};
        if (has_sib) begin
            mem_bytes[1] = SIB_NOIDX;
            for (int j = 0; j < 4; j++) begin
                mem_bytes[2+j] = i_displacement[8*j +: 8];
            end
        end else begin
            for (int j = 0; j < 4; j++) begin
                mem_bytes[1+j] = i_displacement[8*j +: 8];
            end
        end
        mem_len = 4'd1 + {3'd0, has_sib} + disp_len;
    end

    always_comb begin
        desc = '0;
        unique case (t_cmd'(i_cmd)) inside
            CMD_ADD_REG_TO_MEM, CMD_ADD_MEM_TO_REG,
            CMD_MOV_REG_TO_MEM, CMD_MOV_MEM_TO_REG: begin
                desc.bytes[0] = rex_rb;
                case (t_cmd'(i_cmd))
                    CMD_ADD_REG_TO_MEM: desc.bytes[1] = OP_ADD_RM;
                    CMD_ADD_MEM_TO_REG: desc.bytes[1] = OP_ADD_MR;
                    CMD_MOV_REG_TO_MEM: desc.bytes[1] = OP_MOV_RM;
                    default:            desc.bytes[1] = OP_MOV_MR;
                endcase
                for (int j = 0; j < 6; j++) begin
                    desc.bytes[2+j] = mem_bytes[j];
                end
                desc.len = 4'd2 + mem_len;
            end
            CMD_ADD_REG_REG, CMD_MOV_REG_REG: begin
                desc.bytes[0] = rex_rb;
                desc.bytes[1] = (t_cmd'(i_cmd) == CMD_ADD_REG_REG) ? OP_ADD_RM : OP_MOV_RM;
                desc.bytes[2] = MODRM_REG | {2'b00, lo_reg, lo_base};
                desc.len      = 4'd3;
            end
            CMD_ADD_IMM32: begin
                if (i_base_operand == 4'd0) begin
                    desc.bytes[0] = REX_PREFIX | REX_W;
                    desc.bytes[1] = OP_ADD_RAX;
                    for (int j = 0; j < 4; j++) begin
                        desc.bytes[2+j] = i_immediate[8*j +: 8];
                    end
                    desc.len = 4'd6;
                end else begin
                    desc.bytes[0] = rex_b;
                    desc.bytes[1] = OP_GRP1;
                    desc.bytes[2] = MODRM_REG | {5'd0, lo_base};
                    for (int j = 0; j < 4; j++) begin
                        desc.bytes[3+j] = i_immediate[8*j +: 8];
                    end
                    desc.len = 4'd7;
                end
            end
            CMD_MOV_IMM, CMD_MOV_IMM64: begin
                if ((t_cmd'(i_cmd) == CMD_MOV_IMM) && imm_small) begin
                    if (i_base_operand[3]) begin
                        desc.bytes[0] = REX_PREFIX | REX_B;
                        desc.bytes[1] = OP_MOV_IMM | {5'd0, lo_base};
                        for (int j = 0; j < 4; j++) begin
                            desc.bytes[2+j] = i_immediate[8*j +: 8];
                        end
                        desc.len = 4'd6;
                    end else begin
                        desc.bytes[0] = OP_MOV_IMM | {5'd0, lo_base};
                        for (int j = 0; j < 4; j++) begin
                            desc.bytes[1+j] = i_immediate[8*j +: 8];
                        end
                        desc.len = 4'd5;
                    end
                end else begin
                    desc.bytes[0] = rex_b;
                    desc.bytes[1] = OP_MOV_IMM | {5'd0, lo_base};
                    for (int j = 0; j < 8; j++) begin
                        desc.bytes[2+j] = i_immediate[8*j +: 8];
                    end
                    desc.len = 4'd10;
                end
            end
            CMD_CALL_REG: begin
                desc.bytes[0] = rex_b;
                desc.bytes[1] = OP_GRP5;
                desc.bytes[2] = MODRM_CALL | {5'd0, lo_base};
                desc.len      = 4'd3;
            end
            CMD_PUSH_RBP: begin
                desc.bytes[0] = OP_PUSH_BP;
                desc.len      = 4'd1;
            end
            CMD_LEAVE: begin
                desc.bytes[0] = OP_LEAVE;
                desc.len      = 4'd1;
            end
            CMD_RET: begin
                desc.bytes[0] = OP_RET;
                desc.len      = 4'd1;
            end
            default: begin
                // Undefined codes encode to nothing.
                desc.len = 4'd0;
            end
        endcase
    end

    assign o_desc = desc;

endmodule

`default_nettype wire

### hdl/xie_queue.sv
// Descriptor queue between front and back end of the encoder.
// Depends on xie_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module xie_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire xie_pkg::t_desc i_desc,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_nonempty,
    output xie_pkg::t_desc o_desc
);
    import xie_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_desc     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    `XIE_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `XIE_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && !o_nonempty, "pop from empty queue")
    `XIE_ASSERT(a_q_count, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

### hdl/xie_back.sv
// Back end of the encoder: streams each descriptor out one byte per cycle while the output is not stalled.
// Depends on xie_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module xie_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_nonempty,
    input  wire xie_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic [7:0]     o_code_byte,
    output logic           o_last
);
    import xie_pkg::*;
    `include "assert_macros.svh"

    logic       r_busy, n_busy;
    t_byte_vec  r_bytes, n_bytes;
    logic [3:0] r_left, n_left;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       adv;
    logic       load;

    // Output register moves when empty or taken.
    assign adv  = !r_out_valid || i_ready;
    assign load = adv && i_q_nonempty && (!r_busy || (r_left == 4'd1));

    always_comb begin
        n_busy      = r_busy;
        n_bytes     = r_bytes;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_valid = r_busy;
            n_out_byte  = r_bytes[0];
            n_out_last  = (r_left == 4'd1);
            if (r_busy) begin
                n_bytes = {8'h00, r_bytes[MAX_BYTES-1:1]};
                n_left  = r_left - 4'd1;
                n_busy  = (r_left != 4'd1);
            end
            if (load) begin
                n_bytes = i_q_desc.bytes;
                n_left  = i_q_desc.len;
                n_busy  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes    <= n_bytes;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_q_pop     = load;
    assign o_valid     = r_out_valid;
    assign o_code_byte = r_out_byte;
    assign o_last      = r_out_last;

    `XIE_ASSERT(a_b_left, i_clk, i_rst_n,
        !r_busy || (r_left != 4'd0 && r_left <= 4'(MAX_BYTES)), "byte count out of range")
    `XIE_ASSERT(a_b_last, i_clk, i_rst_n,
        (r_busy && r_left == 4'd1 && adv) |=> (r_out_valid && r_out_last),
        "final byte not flagged")
    `XIE_ASSERT(a_b_mid, i_clk, i_rst_n,
        (r_busy && r_left > 4'd1 && adv) |=> (r_out_valid && !r_out_last && r_busy),
        "instruction cut short")

endmodule

`default_nettype wire

### tb/x64_instruction_encoder_checker.sv
// Scoreboard for the x86-64 instruction encoder: watches the request and code
// channels, predicts the code bytes of each accepted request and compares them.
// Depends on xie_pkg for command codes and opcode constants.
`timescale 1ns / 1ps

module x64_instruction_encoder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [3:0]         i_cmd,
    input  logic [3:0]         i_reg_operand,
    input  logic [3:0]         i_base_operand,
    input  logic signed [31:0] i_displacement,
    input  logic [63:0]        i_immediate,
    input  logic               i_code_valid,
    input  logic               i_code_ready,
    input  logic [7:0]         i_code_byte,
    input  logic               i_last,
    output int                 o_mismatch_count,
    output int                 o_pending,
    output int                 o_request_count,
    output int                 o_byte_count
);
    import xie_pkg::*;

    localparam logic [3:0] REG_RAX = 4'd0;
    localparam logic [2:0] LO_RSP  = 3'd4;
    localparam logic [2:0] LO_RBP  = 3'd5;

    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP32  = 2'd2;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_code_exp;

    t_code_exp  code_exp_q[$];
    logic [7:0] insn_bytes[$];

    int mismatch_count = 0;
    int request_count  = 0;
    int byte_count     = 0;

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
        o_request_count  = 0;
        o_byte_count     = 0;
    end

    function automatic logic [7:0] rex_prefix(logic [3:0] reg_num, logic [3:0] base_num,
                                              logic wide);
        logic [7:0] rex;
        rex = REX_PREFIX;
        if (wide)
            rex = rex | REX_W;
        if (reg_num[3])
            rex = rex | REX_R;
        if (base_num[3])
            rex = rex | REX_B;
        return rex;
    endfunction

    function automatic void put_le(logic [63:0] value, int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            insn_bytes.push_back(value[8*i +: 8]);
    endfunction

    // ModRM, optional SIB and displacement of a [base + disp] operand.
    function automatic void put_mem_operand(logic [3:0] reg_num, logic [3:0] base_num,
                                            logic signed [31:0] disp);
        logic [1:0] mode;
        if (disp == 0 && base_num[2:0] != LO_RBP)
            mode = MOD_NO_DISP;
        else if (disp >= -128 && disp <= 127)
            mode = MOD_DISP8;
        else
            mode = MOD_DISP32;
        insn_bytes.push_back({mode, reg_num[2:0], base_num[2:0]});
        if (base_num[2:0] == LO_RSP)
            insn_bytes.push_back(SIB_NOIDX);
        if (mode == MOD_DISP8)
            insn_bytes.push_back(disp[7:0]);
        else if (mode == MOD_DISP32)
            put_le({32'h0, disp}, 4);
    endfunction

    function automatic void put_mov_imm64(logic [3:0] base_num, logic [63:0] imm);
        insn_bytes.push_back(rex_prefix(REG_RAX, base_num, 1'b1));
        insn_bytes.push_back(OP_MOV_IMM | base_num[2:0]);
        put_le(imm, 8);
    endfunction

    // Encode one request and queue its bytes, the final one flagged.
    function automatic void encode_instruction(logic [3:0] cmd, logic [3:0] reg_num,
                                               logic [3:0] base_num, logic signed [31:0] disp,
                                               logic [63:0] imm);
        t_code_exp entry;
        int i;
        insn_bytes.delete();
        case (t_cmd'(cmd))
            CMD_ADD_REG_TO_MEM: begin
                insn_bytes.push_back(rex_prefix(reg_num, base_num, 1'b1));
                insn_bytes.push_back(OP_ADD_RM);
                put_mem_operand(reg_num, base_num, disp);
            end
            CMD_ADD_MEM_TO_REG: begin
                insn_bytes.push_back(rex_prefix(reg_num, base_num, 1'b1));
                insn_bytes.push_back(OP_ADD_MR);
                put_mem_operand(reg_num, base_num, disp);
            end
            CMD_ADD_REG_REG: begin
                insn_bytes.push_back(rex_prefix(reg_num, base_num, 1'b1));
                insn_bytes.push_back(OP_ADD_RM);
                insn_bytes.push_back(MODRM_REG | {2'b00, reg_num[2:0], base_num[2:0]});
            end
            CMD_ADD_IMM32: begin
                if (base_num == REG_RAX) begin
                    insn_bytes.push_back(REX_PREFIX | REX_W);
                    insn_bytes.push_back(OP_ADD_RAX);
                end else begin
                    insn_bytes.push_back(rex_prefix(REG_RAX, base_num, 1'b1));
                    insn_bytes.push_back(OP_GRP1);
                    insn_bytes.push_back(MODRM_REG | base_num[2:0]);
                end
                put_le({32'h0, imm[31:0]}, 4);
            end
            CMD_MOV_IMM: begin
                if (imm[63:32] == 32'h0) begin
                    if (base_num[3])
                        insn_bytes.push_back(REX_PREFIX | REX_B);
                    insn_bytes.push_back(OP_MOV_IMM | base_num[2:0]);
                    put_le(imm, 4);
                end else begin
                    put_mov_imm64(base_num, imm);
                end
            end
            CMD_MOV_IMM64: put_mov_imm64(base_num, imm);
            CMD_MOV_REG_REG: begin
                insn_bytes.push_back(rex_prefix(reg_num, base_num, 1'b1));
                insn_bytes.push_back(OP_MOV_RM);
                insn_bytes.push_back(MODRM_REG | {2'b00, reg_num[2:0], base_num[2:0]});
            end
            CMD_MOV_REG_TO_MEM: begin
                insn_bytes.push_back(rex_prefix(reg_num, base_num, 1'b1));
                insn_bytes.push_back(OP_MOV_RM);
                put_mem_operand(reg_num, base_num, disp);
            end
            CMD_MOV_MEM_TO_REG: begin
                insn_bytes.push_back(rex_prefix(reg_num, base_num, 1'b1));
                insn_bytes.push_back(OP_MOV_MR);
                put_mem_operand(reg_num, base_num, disp);
            end
            CMD_CALL_REG: begin
                insn_bytes.push_back(rex_prefix(REG_RAX, base_num, 1'b1));
                insn_bytes.push_back(OP_GRP5);
                insn_bytes.push_back(MODRM_CALL | base_num[2:0]);
            end
            CMD_PUSH_RBP: insn_bytes.push_back(OP_PUSH_BP);
            CMD_LEAVE:    insn_bytes.push_back(OP_LEAVE);
            CMD_RET:      insn_bytes.push_back(OP_RET);
            default: ;
        endcase
        for (i = 0; i < insn_bytes.size(); i++) begin
            entry.code = insn_bytes[i];
            entry.last = (i == insn_bytes.size() - 1);
            code_exp_q.push_back(entry);
        end
    endfunction

    always @(posedge i_clk) begin
        t_code_exp exp_entry;
        if (!i_rst_n) begin
            code_exp_q.delete();
        end else begin
            if (i_code_valid && i_code_ready) begin
                byte_count++;
                if (code_exp_q.size() == 0) begin
                    $error("unexpected code byte %02h (last %0b) with nothing expected",
                           i_code_byte, i_last);
                    mismatch_count++;
                end else begin
                    exp_entry = code_exp_q.pop_front();
                    if (exp_entry.code !== i_code_byte) begin
                        $error("code_byte mismatch: expected %02h, actual %02h",
                               exp_entry.code, i_code_byte);
                        mismatch_count++;
                    end
                    if (exp_entry.last !== i_last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               exp_entry.last, i_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                request_count++;
                encode_instruction(i_cmd, i_reg_operand, i_base_operand, i_displacement,
                                   i_immediate);
            end
        end
        o_mismatch_count <= mismatch_count;
        o_pending        <= code_exp_q.size();
        o_request_count  <= request_count;
        o_byte_count     <= byte_count;
    end

endmodule

### tb/tb_x64_instruction_encoder_unit.sv
// Testbench top for x64_instruction_encoder_unit: drives requests and code-side
// stalls, and gives the verdict. Depends on xie_pkg and x64_instruction_encoder_checker.
`timescale 1ns / 1ps

module tb_x64_instruction_encoder_unit;
    import xie_pkg::*;

    // Codes past the last defined command: the block takes them and emits nothing.
    localparam logic [3:0] CMD_UNDEF_FIRST = 4'd13;
    localparam logic [3:0] CMD_UNDEF_LAST  = 4'd15;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum logic [3:0] {
        GPR_RAX, GPR_RCX, GPR_RDX, GPR_RBX, GPR_RSP, GPR_RBP, GPR_RSI, GPR_RDI,
        GPR_R8,  GPR_R9,  GPR_R10, GPR_R11, GPR_R12, GPR_R13, GPR_R14, GPR_R15
    } t_gpr;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_cmd;
    logic [3:0]  i_reg_operand;
    logic [3:0]  i_base_operand;
    logic [31:0] i_displacement;
    logic [63:0] i_immediate;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_code_byte;
    logic        o_last;

    int mismatch_count;
    int pending;
    int request_count;
    int byte_count;

    // Flags shared between the request driver and the code-side stall process, and the watchdog counter.
    bit idle_on       = 1'b1;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int stall_cycles  = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    x64_instruction_encoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_reg_operand  (i_reg_operand),
        .i_base_operand (i_base_operand),
        .i_displacement (i_displacement),
        .i_immediate    (i_immediate),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_byte    (o_code_byte),
        .o_last         (o_last)
    );

    x64_instruction_encoder_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_cmd            (i_cmd),
        .i_reg_operand    (i_reg_operand),
        .i_base_operand   (i_base_operand),
        .i_displacement   (i_displacement),
        .i_immediate      (i_immediate),
        .i_code_valid     (o_valid),
        .i_code_ready     (i_ready),
        .i_code_byte      (o_code_byte),
        .i_last           (o_last),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending),
        .o_request_count  (request_count),
        .o_byte_count     (byte_count)
    );

    // Offer one request and hold it until the block takes it. When idling is on,
    // sometimes drop valid for a short random burst first so gaps land on every phase.
    task automatic send_request(input logic [3:0] cmd, input logic [3:0] reg_num,
                                input logic [3:0] base_num, input logic [31:0] disp,
                                input logic [63:0] imm);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_reg_operand  <= reg_num;
        i_base_operand <= base_num;
        i_displacement <= disp;
        i_immediate    <= imm;
        // o_ready seen right after the edge is its value at that edge.
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Favor the sizes where the encoding changes: zero, disp8 bounds, disp32.
    function automatic logic [31:0] rand_displacement();
        logic [7:0]  lo8;
        logic [15:0] lo16;
        lo8  = 8'($urandom);
        lo16 = 16'($urandom);
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return {{24{lo8[7]}}, lo8};
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'hFFFF_FF7F;
                    1: return 32'hFFFF_FF80;
                    2: return 32'h0000_007F;
                    default: return 32'h0000_0080;
                endcase
            end
            3: return {{16{lo16[15]}}, lo16};
            default: return $urandom;
        endcase
    endfunction

    // Mix immediates that fit the short mov with ones that need all 64 bits.
    function automatic logic [63:0] rand_immediate();
        case ($urandom_range(0, 4))
            0: return {32'h0, 32'($urandom)};
            1: begin
                case ($urandom_range(0, 3))
                    0: return 64'h0000_0000_FFFF_FFFF;
                    1: return 64'h0000_0001_0000_0000;
                    2: return 64'h0;
                    default: return '1;
                endcase
            end
            2: return {32'($urandom_range(1, 255)), 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Send the given number of random requests; undefined codes are mixed in.
    task automatic send_random_requests(input int n_requests);
        int sent;
        logic [3:0] cmd;
        sent = 0;
        while (sent < n_requests) begin
            cmd = 4'($urandom_range(CMD_ADD_REG_TO_MEM, CMD_UNDEF_LAST));
            send_request(cmd, 4'($urandom), 4'($urandom), rand_displacement(),
                         rand_immediate());
            sent++;
        end
    endtask

    // Code-side ready: a single long hold-off on request, short random stalls
    // while idling is on, and steady ready otherwise.
    initial begin
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 4);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_RET;
        i_reg_operand  <= GPR_RAX;
        i_base_operand <= GPR_RAX;
        i_displacement <= 32'h0;
        i_immediate    <= 64'h0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: register extremes, every displacement size, the
        // RBP/R13 forced disp8, the RSP/R12 SIB byte, both add-immediate forms,
        // short and long mov immediates, the one-byte commands, undefined codes.
        send_request(CMD_ADD_REG_TO_MEM, GPR_RAX, GPR_RAX, 32'h0, 64'h0);
        send_request(CMD_ADD_MEM_TO_REG, GPR_R15, GPR_R13, 32'h0, '1);
        send_request(CMD_ADD_REG_TO_MEM, GPR_R8,  GPR_RBP, 32'h0, 64'h0);
        send_request(CMD_MOV_REG_TO_MEM, GPR_RBX, GPR_RSP, 32'h0, rand_immediate());
        send_request(CMD_MOV_MEM_TO_REG, GPR_R12, GPR_R12, 32'hFFFF_FF80, 64'h0);
        send_request(CMD_MOV_MEM_TO_REG, GPR_RDI, GPR_RSI, 32'h0000_007F, 64'h0);
        send_request(CMD_MOV_REG_TO_MEM, GPR_RCX, GPR_RDX, 32'h0000_0080, 64'h0);
        send_request(CMD_ADD_MEM_TO_REG, GPR_R9,  GPR_R14, 32'hFFFF_FF7F, 64'h0);
        send_request(CMD_ADD_REG_TO_MEM, GPR_R15, GPR_R15, 32'h7FFF_FFFF, 64'h0);
        send_request(CMD_MOV_MEM_TO_REG, GPR_RAX, GPR_RSP, 32'h8000_0000, 64'h0);
        send_request(CMD_ADD_REG_REG,    GPR_R15, GPR_RAX, $urandom, 64'h0);
        send_request(CMD_ADD_REG_REG,    GPR_RAX, GPR_R15, 32'h0, 64'h0);
        send_request(CMD_ADD_IMM32,      GPR_R11, GPR_RAX, 32'hFFFF_FFFF, '1);
        send_request(CMD_ADD_IMM32,      GPR_RAX, GPR_R8,  32'h0, 64'hDEAD_BEEF_1234_5678);
        send_request(CMD_MOV_IMM,        GPR_R15, GPR_RAX, 32'h0, 64'h0);
        send_request(CMD_MOV_IMM,        GPR_RAX, GPR_R15, 32'h0, 64'h0000_0000_FFFF_FFFF);
        send_request(CMD_MOV_IMM,        GPR_RAX, GPR_RBX, 32'h0, 64'h0000_0001_0000_0000);
        send_request(CMD_MOV_IMM,        GPR_RAX, GPR_R9,  32'h0, '1);
        send_request(CMD_MOV_IMM64,      GPR_RAX, GPR_RAX, 32'h0, 64'h5);
        send_request(CMD_MOV_REG_REG,    GPR_R15, GPR_R8,  32'h0, 64'h0);
        send_request(CMD_CALL_REG,       GPR_R15, GPR_R12, 32'h0, 64'h0);
        send_request(CMD_PUSH_RBP,       GPR_RAX, GPR_RAX, 32'h0, 64'h0);
        send_request(CMD_LEAVE,          GPR_R15, GPR_R15, '1, '1);
        send_request(CMD_RET,            GPR_RAX, GPR_RAX, 32'h0, 64'h0);
        send_request(CMD_UNDEF_FIRST,    GPR_R15, GPR_R15, '1, '1);
        send_request(CMD_UNDEF_LAST,     GPR_RAX, GPR_RAX, 32'h0, 64'h0);

        // Back-pressure: hold off the code side while requests keep coming
        // back to back, so the queue fills and the block stalls its input.
        idle_on      = 1'b0;
        hold_off_req = 1'b1;
        send_random_requests(24);

        // Pause the sender until every outstanding code byte has drained.
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        // Bulk random traffic with stalls on both sides, then a clean tail.
        idle_on = 1'b1;
        send_random_requests(280);
        idle_on = 1'b0;
        send_random_requests(50);

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (all commands, undefined codes, every", request_count);
        $display("displacement size and immediate form) and checked %0d code bytes", byte_count);
        if (mismatch_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
